>>> hw/rtl/i2c_master_bit_engine_unit_defines.svh
// Assertion macros shared by the I2C master bit engine RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define I2CM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm: next-cycle check failed");

`else

`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2CM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/i2cm_pkg.sv
// Package for the I2C master bit engine: phase codes, command codes,
// register indexes, segment lengths and the state and request structs.
// No dependencies.
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST_A = 4'd1,
    PH_ST_B = 4'd2,
    PH_SP_A = 4'd3,
    PH_SP_B = 4'd4,
    PH_WR_D = 4'd5,
    PH_WR_H = 4'd6,
    PH_WR_L = 4'd7,
    PH_WA_A = 4'd8,
    PH_WA_B = 4'd9,
    PH_WA_P = 4'd10,
    PH_RD_L = 4'd11,
    PH_RD_H = 4'd12,
    PH_AK_L = 4'd13,
    PH_AK_H = 4'd14
  } phase_t;

  // Command codes carried in the mode field.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_WACK  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_DELAY_UNIT = 1'b0;
  localparam logic CFG_POLL_LIMIT = 1'b1;

  localparam logic [15:0] DELAY_UNIT_RESET = 16'd1;
  localparam logic [7:0]  POLL_LIMIT_RESET = 8'd250;

  // Segment lengths, stored as the number of further units after the first.
  localparam logic [1:0] SEG_FOUR_LEFT = 2'd3;
  localparam logic [1:0] SEG_TWO_LEFT  = 2'd1;
  localparam logic [1:0] SEG_ONE_LEFT  = 2'd0;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_index;
    logic [7:0]  shift_reg;
    logic [15:0] delay_count;
    logic [1:0]  units_left;
    logic [7:0]  poll_count;
    logic        ack_choice;
    logic [7:0]  rx_hold;
    logic        scl;
    logic        sda;
    logic        drv;
    logic        fail_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_IDLE,
    bit_index:   4'd0,
    shift_reg:   8'd0,
    delay_count: 16'd0,
    units_left:  2'd0,
    poll_count:  8'd0,
    ack_choice:  1'b0,
    rx_hold:     8'd0,
    scl:         1'b1,
    sda:         1'b1,
    drv:         1'b1,
    fail_flag:   1'b0
  };

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_item_t;

endpackage

>>> hw/rtl/i2cm_if.sv
// Request and result channel interfaces of the I2C master bit engine.
// Valid/ready handshake with the payload fields; no dependencies.
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, mode, tx_byte, send_ack, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, mode, tx_byte, send_ack, sda_in,
                output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       ready_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl, sda_out, sda_drive, ready_res, done_res,
                  rx_byte, ack_failed, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, ready_res, done_res,
                rx_byte, ack_failed, output ready);
endinterface

>>> hw/rtl/i2cm_step.sv
// One-tick transition logic of the I2C master bit engine.
// Depends on i2cm_pkg for the state, request and result types.
module i2cm_step import i2cm_pkg::*; (
  input  state_t      st,
  input  cmd_item_t   item,
  input  logic [15:0] delay_unit,
  input  logic [7:0]  poll_limit,
  output state_t      st_next,
  output res_item_t   result
);

  logic [15:0] unit_m1;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_up;
  logic        done;

  // A zero delay unit behaves as a unit of one tick.
  assign unit_m1  = (delay_unit == 16'd0) ? 16'd0 : delay_unit - 16'd1;
  assign bit_inc  = st.bit_index + 4'd1;
  assign shift_up = {st.shift_reg[6:0], 1'b0};

  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        case (item.mode)
          MODE_START: begin
            st_next.drv = 1'b1;
            st_next.sda = 1'b1;
            st_next.scl = 1'b1;
            st_next.phase = PH_ST_A;
            st_next.units_left = SEG_FOUR_LEFT;
            st_next.delay_count = unit_m1;
          end
          MODE_STOP: begin
            st_next.drv = 1'b1;
            st_next.scl = 1'b0;
            st_next.sda = 1'b0;
            st_next.phase = PH_SP_A;
            st_next.units_left = SEG_FOUR_LEFT;
            st_next.delay_count = unit_m1;
          end
          MODE_WRITE: begin
            st_next.shift_reg = item.tx_byte;
            st_next.bit_index = 4'd0;
            st_next.drv = 1'b1;
            st_next.scl = 1'b0;
            st_next.sda = item.tx_byte[7];
            st_next.phase = PH_WR_D;
            st_next.units_left = SEG_TWO_LEFT;
            st_next.delay_count = unit_m1;
          end
          MODE_WACK: begin
            st_next.fail_flag = 1'b0;
            st_next.poll_count = 8'd0;
            st_next.drv = 1'b0;
            st_next.sda = 1'b1;
            st_next.phase = PH_WA_A;
            st_next.units_left = SEG_ONE_LEFT;
            st_next.delay_count = unit_m1;
          end
          MODE_READ: begin
            st_next.shift_reg = 8'd0;
            st_next.bit_index = 4'd0;
            st_next.ack_choice = item.send_ack;
            st_next.drv = 1'b0;
            st_next.scl = 1'b0;
            st_next.phase = PH_RD_L;
            st_next.units_left = SEG_TWO_LEFT;
            st_next.delay_count = unit_m1;
          end
          default: begin
          end
        endcase
      end
    end else if (st.delay_count != 16'd0) begin
      st_next.delay_count = st.delay_count - 16'd1;
    end else if (st.units_left != 2'd0) begin
      st_next.units_left = st.units_left - 2'd1;
      st_next.delay_count = unit_m1;
    end else begin
      case (st.phase)
        PH_ST_A: begin
          st_next.sda = 1'b0;
          st_next.phase = PH_ST_B;
          st_next.units_left = SEG_FOUR_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_ST_B: begin
          st_next.scl = 1'b0;
          st_next.phase = PH_IDLE;
          done = 1'b1;
        end
        PH_SP_A: begin
          st_next.scl = 1'b1;
          st_next.sda = 1'b1;
          st_next.phase = PH_SP_B;
          st_next.units_left = SEG_FOUR_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_SP_B: begin
          st_next.phase = PH_IDLE;
          done = 1'b1;
        end
        PH_WR_D: begin
          st_next.scl = 1'b1;
          st_next.phase = PH_WR_H;
          st_next.units_left = SEG_TWO_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_WR_H: begin
          st_next.scl = 1'b0;
          st_next.phase = PH_WR_L;
          st_next.units_left = SEG_TWO_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_WR_L: begin
          st_next.bit_index = bit_inc;
          if (bit_inc >= BYTE_BITS) begin
            st_next.phase = PH_IDLE;
            done = 1'b1;
          end else begin
            st_next.shift_reg = shift_up;
            st_next.sda = shift_up[7];
            st_next.phase = PH_WR_D;
            st_next.units_left = SEG_TWO_LEFT;
            st_next.delay_count = unit_m1;
          end
        end
        PH_WA_A: begin
          st_next.scl = 1'b1;
          st_next.phase = PH_WA_B;
          st_next.units_left = SEG_ONE_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_WA_B, PH_WA_P: begin
          // One poll per tick while SCL is high.
          st_next.phase = PH_WA_P;
          if (!item.sda_in) begin
            st_next.scl = 1'b0;
            st_next.fail_flag = 1'b0;
            st_next.phase = PH_IDLE;
            done = 1'b1;
          end else if (st.poll_count >= poll_limit) begin
            // Timed out: flag it and run a stop condition.
            st_next.fail_flag = 1'b1;
            st_next.drv = 1'b1;
            st_next.scl = 1'b0;
            st_next.sda = 1'b0;
            st_next.phase = PH_SP_A;
            st_next.units_left = SEG_FOUR_LEFT;
            st_next.delay_count = unit_m1;
          end else begin
            st_next.poll_count = st.poll_count + 8'd1;
          end
        end
        PH_RD_L: begin
          st_next.scl = 1'b1;
          st_next.shift_reg = {st.shift_reg[6:0], item.sda_in};
          st_next.phase = PH_RD_H;
          st_next.units_left = SEG_ONE_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_RD_H: begin
          st_next.bit_index = bit_inc;
          st_next.scl = 1'b0;
          st_next.delay_count = unit_m1;
          st_next.units_left = SEG_TWO_LEFT;
          if (bit_inc >= BYTE_BITS) begin
            st_next.drv = 1'b1;
            st_next.sda = ~st.ack_choice;
            st_next.phase = PH_AK_L;
          end else begin
            st_next.phase = PH_RD_L;
          end
        end
        PH_AK_L: begin
          st_next.scl = 1'b1;
          st_next.phase = PH_AK_H;
          st_next.units_left = SEG_TWO_LEFT;
          st_next.delay_count = unit_m1;
        end
        PH_AK_H: begin
          st_next.scl = 1'b0;
          st_next.rx_hold = st.shift_reg;
          st_next.phase = PH_IDLE;
          done = 1'b1;
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.scl        = st_next.scl;
    result.sda_out    = st_next.sda;
    result.sda_drive  = st_next.drv;
    result.ready_res  = (st_next.phase == PH_IDLE);
    result.done_res   = done;
    result.rx_byte    = st_next.rx_hold;
    result.ack_failed = st_next.fail_flag;
  end

endmodule

>>> hw/rtl/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: state, configuration and result
// registers around the one-tick transition logic.
// Depends on i2cm_pkg, i2cm_if.sv, i2cm_step and the assertion macro header.

// The engine drives the SCL and SDA pins of an I2C bus one tick at a time.
// Every request on the cmd channel is one tick: it carries the sampled SDA
// level and may offer a command (start, stop, write byte MSB first, wait for
// acknowledge, read byte with ACK or NACK). Each request gives exactly one
// result on the res channel with the pin levels after that tick, the ready
// and done flags, the last received byte and the acknowledge failure flag.
// Commands are only taken when the engine is idle at the start of a tick.
// Bus timing is built from delay units of delay_unit_ticks ticks each
// (register 0, a zero value acts as one); the acknowledge wait gives up after
// ack_poll_limit + 1 high polls (register 1) and then issues a stop.
// Throughput is one request per clock cycle: the tick's whole transition is
// one pass of logic from the state register into the state and result
// registers, so a request is taken every cycle while the result register is
// empty or being drained. Each accepted request's result is registered.
// Configuration must only be written while the engine is idle.
`include "i2c_master_bit_engine_unit_defines.svh"

module i2c_master_bit_engine_unit import i2cm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  i2cm_cmd_if.sink     cmd,
  i2cm_res_if.source   res,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  state_t      st;
  state_t      st_next;
  cmd_item_t   item;
  res_item_t   step_res;
  res_item_t   res_data;
  logic        res_valid;
  logic        cmd_ready;
  logic        cmd_fire;
  logic [15:0] delay_unit;
  logic [7:0]  poll_limit;
  logic        count_down;
  logic        fail_rise;
  logic        in_poll;

  // A request can enter whenever the result register is empty or its
  // content leaves in the same cycle.
  assign cmd_ready = !res_valid || res.ready;
  assign cmd_fire  = cmd.valid && cmd_ready;
  assign cmd.ready = cmd_ready;

  always_comb begin
    item.cmd_valid = cmd.cmd_valid;
    item.mode      = cmd.mode;
    item.tx_byte   = cmd.tx_byte;
    item.send_ack  = cmd.send_ack;
    item.sda_in    = cmd.sda_in;
  end

  i2cm_step u_step (
    .st         (st),
    .item       (item),
    .delay_unit (delay_unit),
    .poll_limit (poll_limit),
    .st_next    (st_next),
    .result     (step_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_unit <= DELAY_UNIT_RESET;
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_UNIT: delay_unit <= cfg_data;
        CFG_POLL_LIMIT: poll_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Engine state advances by one tick per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (cmd_fire) begin
      st <= st_next;
    end
  end

  // Result register: the payload needs no reset, only its valid flag does.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_data <= step_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.scl        = res_data.scl;
  assign res.sda_out    = res_data.sda_out;
  assign res.sda_drive  = res_data.sda_drive;
  assign res.ready_res  = res_data.ready_res;
  assign res.done_res   = res_data.done_res;
  assign res.rx_byte    = res_data.rx_byte;
  assign res.ack_failed = res_data.ack_failed;

  assign count_down = cmd_fire && (st.phase != PH_IDLE) && (st.delay_count != 16'd0);
  assign fail_rise  = cmd_fire && !st.fail_flag && st_next.fail_flag;
  assign in_poll    = (st.phase == PH_WA_B) || (st.phase == PH_WA_P);

  // Every accepted request leaves a result in the output register.
  `I2CM_ASSERT_NXT(a_result_follows, clk, rst, cmd_fire, res_valid)
  // A busy tick with time left in the segment only counts the delay down.
  `I2CM_ASSERT_NXT(a_delay_countdown, clk, rst, count_down, st.delay_count == $past(st.delay_count) - 16'd1)
  // The failure flag can only be raised by an acknowledge poll.
  `I2CM_ASSERT_IMP(a_fail_from_poll, clk, rst, fail_rise, in_poll)
  // The bit counter never runs past one byte.
  `I2CM_ASSERT_IMP(a_bit_range, clk, rst, 1'b1, st.bit_index <= BYTE_BITS)

endmodule
